/* design/crcdf_pkg.sv */
// Shared constants, types and CRC-8 helpers for the CRC-8 frame deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package crcdf_pkg;

    localparam int WIN_DEPTH = 8;   // bytes held before the current one
    localparam int PAY_FIRST = 2;   // window slot of the first payload byte
    localparam int PAY_LEN   = 5;   // payload bytes per frame
    localparam int OUT_W     = 8 * PAY_LEN;

    localparam logic [7:0] HDR0     = 8'h01;
    localparam logic [7:0] HDR1     = 8'h02;
    localparam logic [7:0] TRAILER  = 8'h5A;
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_MSB  = 8'h80;

    // Control fanned out to every window cell
    typedef struct packed {
        logic shift;    // take neighbor byte, advance running CRC
        logic clear;    // valid frame seen: back to the empty-window state
    } crcdf_ctl_t;

    // One byte through CRC-8, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            if ((c & CRC_MSB) != 8'h00) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

    // CRC state after a run of zero bytes; used only with constant counts
    function automatic logic [7:0] crc8_zeros(input int count);
        logic [7:0] c;
        c = CRC_INIT;
        for (int n = 0; n < WIN_DEPTH; n++) begin
            if (n < count) begin
                c = crc8_byte(c, 8'h00);
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* design/crcdf_cell.sv */
// One window cell: a received byte plus the running CRC over this slot and
// every newer slot. Depends on crcdf_pkg.
`default_nettype none

module crcdf_cell (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire crcdf_pkg::crcdf_ctl_t  ctl,
    input  wire logic [7:0]             byte_in,   // from newer neighbor
    input  wire logic [7:0]             crc_in,    // newer neighbor's CRC
    input  wire logic [7:0]             rx_byte,   // byte being accepted
    input  wire logic [7:0]             crc_rst,   // CRC of an all-zero tail
    output logic [7:0]                  byte_q,
    output logic [7:0]                  crc_q
);
    import crcdf_pkg::*;

    logic [7:0] byte_reg, byte_next;
    logic [7:0] crc_reg, crc_next;

    // Clear to the empty-window state, or shift in neighbor byte; CRC of this slot onward gains the new byte
    always_comb begin
        byte_next = byte_reg;
        crc_next  = crc_reg;
        if (ctl.clear) begin
            byte_next = 8'h00;
            crc_next  = crc_rst;
        end else if (ctl.shift) begin
            byte_next = byte_in;
            crc_next  = crc8_byte(crc_in, rx_byte);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'h00;
            crc_reg  <= crc_rst;
        end else begin
            byte_reg <= byte_next;
            crc_reg  <= crc_next;
        end
    end

    assign byte_q = byte_reg;
    assign crc_q  = crc_reg;

endmodule

`default_nettype wire

/* design/crcdf_out.sv */
// Result register for the deframer: holds one payload request until taken.
// Depends on crcdf_pkg.
`default_nettype none

module crcdf_out (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        load,
    input  wire logic [crcdf_pkg::OUT_W-1:0] payload,
    input  wire logic                        m_tready,
    output logic                             m_tvalid,
    output logic [crcdf_pkg::OUT_W-1:0]      m_tdata,
    output logic                             room      // free for a new request
);
    import crcdf_pkg::*;

    logic             valid_reg, valid_next;
    logic [OUT_W-1:0] data_reg;

    assign room = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= payload;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    property p_load_needs_room;
        @(posedge aclk) disable iff (!aresetn)
        load |-> (!valid_reg || m_tready);
    endproperty
    a_load_needs_room: assert property (p_load_needs_room)
        else $error("result loaded over a request not yet taken");

    property p_load_shows;
        @(posedge aclk) disable iff (!aresetn)
        load |=> (m_tvalid && m_tdata == $past(payload));
    endproperty
    a_load_shows: assert property (p_load_shows)
        else $error("loaded payload not presented");

    property p_idle_drains;
        @(posedge aclk) disable iff (!aresetn)
        (!load && m_tready) |=> !m_tvalid;
    endproperty
    a_idle_drains: assert property (p_idle_drains)
        else $error("taken request still shown");

endmodule

`default_nettype wire

/* design/crc8_frame_deframer.sv */
// A valid frame's payload is presented on m_tdata in the cycle after its
// trailer byte is accepted. Throughput: one byte per cycle; the window
// is a row of eight byte cells, each with a one-byte CRC step, so the whole
// frame check is combinational. s_tready drops only while a result waits.
// Reset (aresetn low, synchronous) empties the window and drops any result.
// Depends on crcdf_pkg, crcdf_cell and crcdf_out.
`default_nettype none

module crc8_frame_deframer (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] rx_byte
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [7:0] payload_0, [15:8] payload_1, [23:16] payload_2,
    // [31:24] payload_3, [39:32] payload_4
    output logic [crcdf_pkg::OUT_W-1:0]      m_tdata
);
    import crcdf_pkg::*;

    logic             accept;
    logic             hit;
    logic             room;
    crcdf_ctl_t       ctl;
    logic [7:0]       byte_q    [WIN_DEPTH];
    logic [7:0]       crc_chain [WIN_DEPTH+1];
    logic [OUT_W-1:0] payload;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    // Cell j keeps the CRC over slots j..newest; the empty tail reads as init
    assign crc_chain[WIN_DEPTH] = CRC_INIT;

    // Window row: slot 0 oldest, last slot newest
    for (genvar j = 0; j < WIN_DEPTH; j++) begin : g_cell
        logic [7:0] byte_in;
        if (j == WIN_DEPTH - 1) begin : g_head
            assign byte_in = s_tdata;
        end else begin : g_body
            assign byte_in = byte_q[j+1];
        end
        crcdf_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .byte_in (byte_in),
            .crc_in  (crc_chain[j+1]),
            .rx_byte (s_tdata),
            .crc_rst (crc8_zeros(WIN_DEPTH - j)),
            .byte_q  (byte_q[j]),
            .crc_q   (crc_chain[j])
        );
    end

    // CRC over payload plus its check byte leaves zero exactly when it matches
    assign hit = (byte_q[0] == HDR0) && (byte_q[1] == HDR1) &&
                 (s_tdata == TRAILER) && (crc_chain[PAY_FIRST] == 8'h00);

    assign ctl.shift = accept && !hit;
    assign ctl.clear = accept && hit;

    for (genvar k = 0; k < PAY_LEN; k++) begin : g_pay
        assign payload[8*k +: 8] = byte_q[PAY_FIRST + k];
    end

    crcdf_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (ctl.clear),
        .payload  (payload),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .room     (room)
    );

    property p_hit_clears;
        @(posedge aclk) disable iff (!aresetn)
        ctl.clear |=> (byte_q[0] == 8'h00 && byte_q[1] == 8'h00 &&
                       byte_q[WIN_DEPTH-1] == 8'h00);
    endproperty
    a_hit_clears: assert property (p_hit_clears)
        else $error("window not emptied after a frame");

    property p_shift_takes_byte;
        @(posedge aclk) disable iff (!aresetn)
        ctl.shift |=> (byte_q[WIN_DEPTH-1] == $past(s_tdata));
    endproperty
    a_shift_takes_byte: assert property (p_shift_takes_byte)
        else $error("accepted byte missing from newest slot");

    property p_head_crc;
        @(posedge aclk) disable iff (!aresetn)
        crc_chain[WIN_DEPTH-1] == crc8_byte(CRC_INIT, byte_q[WIN_DEPTH-1]);
    endproperty
    a_head_crc: assert property (p_head_crc)
        else $error("running CRC out of step with window");

    property p_hit_needs_accept;
        @(posedge aclk) disable iff (!aresetn)
        ctl.clear |-> (s_tvalid && s_tready);
    endproperty
    a_hit_needs_accept: assert property (p_hit_needs_accept)
        else $error("frame taken without a request");

endmodule

`default_nettype wire

/* tb/crc8_frame_deframer_tb.sv */
// Self-checking bench for crc8_frame_deframer: byte stream in, payload results out.
// Depends on crcdf_pkg and the RTL of the block; the frame finder is predicted here.
`default_nettype none

module crc8_frame_deframer_tb;

    import crcdf_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [1:0] {
        ROW_BYTE,       // byte taken from the table as written
        ROW_GOOD_CRC,   // CRC of the last five bytes fed
        ROW_BAD_CRC     // inverted CRC of the last five bytes fed
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [7:0]         value;
        bit                 typed;          // expectation written in the row
        bit                 typed_hit;
        logic [OUT_W-1:0]   typed_payload;
    } stim_row_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = 8'h00;   // [7:0] rx_byte
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    // [7:0] payload_0, [15:8] payload_1, [23:16] payload_2,
    // [31:24] payload_3, [39:32] payload_4
    logic [OUT_W-1:0]  m_tdata;

    // Predictor state and bookkeeping
    logic [7:0]        frame_window [WIN_DEPTH];
    logic [OUT_W-1:0]  pending_payloads [$];
    stim_row_t         directed_rows [$];
    bit                quiet        = 1'b0;
    int                cycle_count  = 0;
    int                mismatches   = 0;
    int                bytes_fed    = 0;
    int                frames_found = 0;
    int                results_seen = 0;
    int                stall_left   = 0;

    crc8_frame_deframer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("ERROR at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // CRC-8, poly 0x31, init 0xFF, MSB first; byte k of the payload at [8k+:8]
    function automatic logic [7:0] crc8_over_payload(input logic [OUT_W-1:0] payload);
        logic [7:0] crc;
        logic       msb;
        crc = CRC_INIT;
        for (int k = 0; k < PAY_LEN; k++) begin
            crc = crc ^ payload[8*k +: 8];
            for (int b = 0; b < 8; b++) begin
                msb = crc[7];
                crc = {crc[6:0], 1'b0} ^ (msb ? CRC_POLY : 8'h00);
            end
        end
        return crc;
    endfunction

    // Frame check on each accepted byte, then clear or shift the window
    task automatic track_frame_window(input logic [7:0] rx, output bit hit,
                                      output logic [OUT_W-1:0] found);
        for (int k = 0; k < PAY_LEN; k++) begin
            found[8*k +: 8] = frame_window[PAY_FIRST + k];
        end
        hit = frame_window[0] == HDR0 && frame_window[1] == HDR1 && rx == TRAILER &&
              crc8_over_payload(found) == frame_window[WIN_DEPTH-1];
        if (hit) begin
            pending_payloads.push_back(found);
            frames_found++;
            for (int k = 0; k < WIN_DEPTH; k++) begin
                frame_window[k] = 8'h00;
            end
        end else begin
            for (int k = 0; k < WIN_DEPTH - 1; k++) begin
                frame_window[k] = frame_window[k+1];
            end
            frame_window[WIN_DEPTH-1] = rx;
        end
    endtask

    // Present one byte request, with an optional gap, and hold it until taken
    task automatic feed_rx_byte(input logic [7:0] rx, output bit hit,
                                output logic [OUT_W-1:0] found);
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        do @(posedge aclk); while (s_tready !== 1'b1);
        bytes_fed++;
        track_frame_window(rx, hit, found);
    endtask

    task automatic add_row(input row_kind_t kind, input logic [7:0] value,
                           input bit typed, input bit typed_hit,
                           input logic [OUT_W-1:0] typed_payload);
        stim_row_t row;
        row.kind          = kind;
        row.value         = value;
        row.typed         = typed;
        row.typed_hit     = typed_hit;
        row.typed_payload = typed_payload;
        directed_rows.push_back(row);
    endtask

    // Mostly random bytes, some drawn from the framing codes and extremes
    function automatic logic [7:0] pick_byte();
        logic [7:0] v;
        case ($urandom_range(0, 11))
            0:       v = HDR0;
            1:       v = HDR1;
            2:       v = TRAILER;
            3:       v = 8'h00;
            4:       v = 8'hFF;
            default: v = 8'($urandom_range(0, 255));
        endcase
        return v;
    endfunction

    // Result receiver: random stall bursts, none near the end
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker, field by field against the oldest expectation
    always @(posedge aclk) begin
        logic [OUT_W-1:0] want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            results_seen++;
            if (pending_payloads.size() == 0) begin
                report_mismatch($sformatf("result %h with no frame expected", m_tdata));
            end else begin
                want = pending_payloads.pop_front();
                for (int k = 0; k < PAY_LEN; k++) begin
                    if (m_tdata[8*k +: 8] !== want[8*k +: 8]) begin
                        report_mismatch($sformatf("payload_%0d got %h want %h",
                                                  k, m_tdata[8*k +: 8], want[8*k +: 8]));
                    end
                end
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d frames still expected",
                 cycle_count, pending_payloads.size());
        $display("FAILURE");
        $finish;
    end

    initial begin
        bit               hit;
        logic [OUT_W-1:0] found;
        logic [OUT_W-1:0] body;
        logic [OUT_W-1:0] last5;
        logic [7:0]       value;
        logic [7:0]       hdr1;
        logic [7:0]       crc;
        logic [7:0]       trail;
        int               shape;
        int               body_len;
        int               directed_len;

        for (int k = 0; k < WIN_DEPTH; k++) begin
            frame_window[k] = 8'h00;
        end

        // Bad CRC frame with header codes inside the payload, first byte after reset
        add_row(ROW_BYTE,     HDR0,    1, 0, '0);
        add_row(ROW_BYTE,     HDR1,    0, 0, '0);
        add_row(ROW_BYTE,     8'hA5,   0, 0, '0);
        add_row(ROW_BYTE,     TRAILER, 0, 0, '0);
        add_row(ROW_BYTE,     HDR0,    0, 0, '0);
        add_row(ROW_BYTE,     HDR1,    0, 0, '0);
        add_row(ROW_BYTE,     8'h80,   0, 0, '0);
        add_row(ROW_BAD_CRC,  8'h00,   0, 0, '0);
        add_row(ROW_BYTE,     TRAILER, 1, 0, '0);
        // Valid frame, all-zero payload
        add_row(ROW_BYTE,     HDR0,    0, 0, '0);
        add_row(ROW_BYTE,     HDR1,    0, 0, '0);
        repeat (PAY_LEN) add_row(ROW_BYTE, 8'h00, 0, 0, '0);
        add_row(ROW_GOOD_CRC, 8'h00,   0, 0, '0);
        add_row(ROW_BYTE,     TRAILER, 1, 1, '0);
        // Valid frame, all-ones payload, starting on a cleared window
        add_row(ROW_BYTE,     HDR0,    0, 0, '0);
        add_row(ROW_BYTE,     HDR1,    0, 0, '0);
        repeat (PAY_LEN) add_row(ROW_BYTE, 8'hFF, 0, 0, '0);
        add_row(ROW_GOOD_CRC, 8'h00,   0, 0, '0);
        add_row(ROW_BYTE,     TRAILER, 1, 1, {OUT_W{1'b1}});

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed table
        foreach (directed_rows[i]) begin
            for (int k = 0; k < PAY_LEN; k++) begin
                last5[8*k +: 8] = frame_window[WIN_DEPTH - PAY_LEN + k];
            end
            case (directed_rows[i].kind)
                ROW_GOOD_CRC: value = crc8_over_payload(last5);
                ROW_BAD_CRC:  value = ~crc8_over_payload(last5);
                default:      value = directed_rows[i].value;
            endcase
            feed_rx_byte(value, hit, found);
            if (directed_rows[i].typed &&
                (hit != directed_rows[i].typed_hit ||
                 (hit && found !== directed_rows[i].typed_payload))) begin
                report_mismatch($sformatf("row %0d: predicted %0b/%h, table has %0b/%h",
                                          i, hit, found, directed_rows[i].typed_hit,
                                          directed_rows[i].typed_payload));
            end
        end
        directed_len = bytes_fed;

        // Random frames: mostly well formed, some broken, with noise between them
        while (bytes_fed < directed_len + RANDOM_ITEMS) begin
            quiet = bytes_fed > directed_len + (RANDOM_ITEMS * 7) / 8;
            shape = $urandom_range(0, 9);
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 4)) feed_rx_byte(pick_byte(), hit, found);
            end
            for (int k = 0; k < PAY_LEN; k++) begin
                body[8*k +: 8] = pick_byte();
            end
            crc   = crc8_over_payload(body);
            hdr1  = HDR1;
            trail = TRAILER;
            body_len = PAY_LEN;
            case (shape)
                6: body_len = $urandom_range(0, PAY_LEN - 1);       // cut short
                7: crc   = crc ^ (8'h01 << $urandom_range(0, 7));   // CRC error
                8: trail = trail ^ (8'h01 << $urandom_range(0, 7)); // bad trailer
                9: hdr1  = hdr1 ^ (8'h01 << $urandom_range(0, 7));  // bad header
                default: ;
            endcase
            feed_rx_byte(HDR0, hit, found);
            feed_rx_byte(hdr1, hit, found);
            for (int k = 0; k < body_len; k++) begin
                feed_rx_byte(body[8*k +: 8], hit, found);
            end
            if (body_len == PAY_LEN) begin
                feed_rx_byte(crc, hit, found);
                feed_rx_byte(trail, hit, found);
            end
        end

        quiet = 1'b1;
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (pending_payloads.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Fed %0d bytes (%0d from the directed table) with random gaps and stalls",
                 bytes_fed, directed_len);
        $display("Frames predicted %0d, results checked %0d, mismatches %0d",
                 frames_found, results_seen, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
design/crcdf_pkg.sv
design/crcdf_cell.sv
design/crcdf_out.sv
design/crc8_frame_deframer.sv
tb/crc8_frame_deframer_tb.sv
